FILE: sv/crcb_pkg.sv
// Shared types, constants and the byte-wide CRC fold for the CRC-16 byte stream.
// No dependencies; used by crcb_step and crc16_ccitt_byte_stream.
package crcb_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned CRC_W  = 16;
  localparam int unsigned USER_W = 2;

  localparam logic [CRC_W-1:0] CRC_POLY       = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT_RESET = 16'hC78C;

  // Bit positions inside s_axis_tuser
  localparam int unsigned USER_HAS_BYTE = 0;
  localparam int unsigned USER_FIRST    = 1;

  // One input item as held in the input register
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              has_byte;
    logic              first;
    logic              last;
  } item_t;

  // Fold one byte into the CRC, MSB first, eight shift/XOR steps
  function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [DATA_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = crc ^ {b, {(CRC_W-DATA_W){1'b0}}};
    for (int k = 0; k < DATA_W; k++) begin
      if (r[CRC_W-1]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/crcb_step.sv
// Next-state logic of the running CRC for one item: optional reload, optional byte fold.
// Depends on crcb_pkg.
module crcb_step (
  input  logic [crcb_pkg::CRC_W-1:0] crc_in,
  input  logic [crcb_pkg::CRC_W-1:0] init,
  input  crcb_pkg::item_t            item,
  output logic [crcb_pkg::CRC_W-1:0] crc_out
);

  logic [crcb_pkg::CRC_W-1:0] base;

  // Start of message reloads before the byte goes in
  assign base = item.first ? init : crc_in;

  assign crc_out = item.has_byte ? crcb_pkg::fold_byte(base, item.data_byte) : base;

endmodule

FILE: sv/crc16_ccitt_byte_stream.sv
// Top level of the CRC-16 (poly 0x1021, MSB first) byte stream block.
// Depends on crcb_pkg and crcb_step.
//
// Takes one byte per cycle while s_axis_tready is high and emits one result
// per message, on the item flagged tlast. A transaction on the input goes
// into an input register; from there the byte is folded into the running CRC
// by a combinational XOR network and, for a last item, the CRC lands in the
// output register. So the sustained rate is one item per clock when the
// output does not stall, and the result passes through the input register
// and then the result register. Input ready drops only while the output
// register is full, not taken, and the input register holds a last item.
// initial_value (reset 0xC78C) is loaded on each item with the first flag.
module crc16_ccitt_byte_stream (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [crcb_pkg::CRC_W-1:0]    cfg_data,     // initial_value
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [crcb_pkg::DATA_W-1:0]   s_axis_tdata, // [7:0] data_byte
  input  logic [crcb_pkg::USER_W-1:0]   s_axis_tuser, // [0] has_byte, [1] first
  input  logic                          s_axis_tlast, // last
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [crcb_pkg::CRC_W-1:0]    m_axis_tdata  // [7:0] crc_high, [15:8] crc_low
);

  logic [crcb_pkg::CRC_W-1:0] initial_value;
  logic [crcb_pkg::CRC_W-1:0] running_crc;
  logic [crcb_pkg::CRC_W-1:0] crc_next;
  crcb_pkg::item_t            in_item;
  logic                       in_valid;
  logic                       out_free;
  logic                       in_go;
  logic                       s_fire;

  // Configuration is always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_value <= crcb_pkg::CRC_INIT_RESET;
    end else if (cfg_valid) begin
      initial_value <= cfg_data;
    end
  end

  // Handshake control
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign in_go         = in_valid && (!in_item.last || out_free);
  assign s_axis_tready = !in_valid || in_go;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item.data_byte <= s_axis_tdata;
      in_item.has_byte  <= s_axis_tuser[crcb_pkg::USER_HAS_BYTE];
      in_item.first     <= s_axis_tuser[crcb_pkg::USER_FIRST];
      in_item.last      <= s_axis_tlast;
    end
  end

  // CRC update
  crcb_step u_step (
    .crc_in  (running_crc),
    .init    (initial_value),
    .item    (in_item),
    .crc_out (crc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= crcb_pkg::CRC_INIT_RESET;
    end else if (in_go) begin
      running_crc <= crc_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_go && in_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && in_item.last) begin
      m_axis_tdata <= {crc_next[7:0], crc_next[15:8]};
    end
  end

endmodule

FILE: sv/crcb_checker.sv
// Port-level checker for crc16_ccitt_byte_stream, attached with bind.
// Depends on nothing but the top level's ports.
module crcb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A fresh result follows a last-item transaction through the input and result registers
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without a last item");

  // Input back-pressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

endmodule

bind crc16_ccitt_byte_stream crcb_checker u_crcb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
